// File: src/ffha_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the header allocator.
package ffha_pkg;

   localparam int REGION_BYTES_DEF = 4096;   // default managed region size
   localparam int LEN_W            = 13;     // payload length / size fields
   localparam int OFF_W            = 12;     // payload offset fields
   localparam int CODE_W           = 2;      // result code field
   localparam int CSR_RESET        = 4096;   // region_bytes after reset
   localparam int HDR_BYTES        = 10;     // header size in bytes
   localparam int USAGE_WORD       = 8;      // first header offset

   // header status codes
   localparam logic [1:0] ST_NEVER = 2'd0;
   localparam logic [1:0] ST_INUSE = 2'd1;
   localparam logic [1:0] ST_FREED = 2'd2;

   // opcodes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      RC_OK      = 2'd0,
      RC_ZERO    = 2'd1,
      RC_NOSPACE = 2'd2,
      RC_NOTUSED = 2'd3
   } code_type;

   // controller -> datapath
   typedef struct packed {
      logic     load;       // capture a new item, restart the walk
      logic     clr_wr;     // clear one header entry
      logic     advance;    // step to the next header
      logic     new_wr;     // open a new block at the current header
      logic     reuse_wr;   // reuse the freed block at the current header
      logic     rel_wr;     // mark the addressed block freed
      logic     respond;    // emit a result item
      code_type code;
      logic     grant;      // result carries a payload offset
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       clear_done;
      logic       is_release;
      logic       rel_bad;
      logic       zero_req;
      logic       cur_lt_cap;
      logic       fits;
      logic       len_ge_n;
      logic [1:0] status;
   } sts_type;

endpackage

// File: src/first_fit_header_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the first-fit allocator with in-band block headers.
//
// First-fit allocator over a byte region holding an 8-byte usage word and a
// chain of blocks, each a 10-byte header (status, payload length) and payload.
// Drive an item with start while busy is low; it is taken on that edge. The
// result is shown for exactly one cycle with rsp_valid high and cannot be held
// off: capture it then. After reset the header store is cleared one entry per
// cycle, and busy stays high until all REGION_BYTES entries (4096 by default)
// are cleared, before the first item is taken. An allocate visits each header
// as a registered read of the header store, then the fit decision and pointer
// step; a walk that runs off the region end, and a zero-size request, are
// answered at a read step. A release takes the read step and then the release
// step, or the read step alone when its offset cannot name a header. busy
// drops at the edge that raises rsp_valid, so the result shows in the first
// cycle busy is low, and the next item can be taken at the end of that same
// cycle.
// csr_region_bytes is always ready and sets the usable size (capped at
// REGION_BYTES); write it only while no item is in progress.
module first_fit_header_allocator_top
   import ffha_pkg::*;
#(
   parameter int REGION_BYTES = REGION_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // item request
   input  logic              start,
   output logic              busy,
   input  logic              req_opcode,
   input  logic [LEN_W-1:0]  req_request_bytes,
   input  logic [OFF_W-1:0]  req_release_offset,
   // result strobe
   output logic              rsp_valid,
   output logic [OFF_W-1:0]  rsp_payload_offset,
   output logic [CODE_W-1:0] rsp_result_code,
   output logic [LEN_W-1:0]  rsp_bytes_in_use,
   // region size register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LEN_W-1:0]  csr_region_bytes
);

   cmd_type  cmd;
   sts_type  sts;
   code_type rsp_code;
   logic     csr_we;

   // the register takes a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   ffha_datapath #(
      .REGION_BYTES (REGION_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_release_offset (req_release_offset),
      .csr_we             (csr_we),
      .csr_region_bytes   (csr_region_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_result_code    (rsp_code),
      .rsp_bytes_in_use   (rsp_bytes_in_use)
   );

   assign rsp_result_code = rsp_code;

endmodule

// File: src/ffha_datapath.sv
`timescale 1ns / 1ps
// Datapath: header store, walk pointer, usage counter, config register and result registers.
module ffha_datapath
   import ffha_pkg::*;
#(
   parameter int REGION_BYTES = REGION_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic             req_opcode,
   input  logic [LEN_W-1:0] req_request_bytes,
   input  logic [OFF_W-1:0] req_release_offset,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_region_bytes,
   output logic             rsp_valid,
   output logic [OFF_W-1:0] rsp_payload_offset,
   output code_type         rsp_result_code,
   output logic [LEN_W-1:0] rsp_bytes_in_use
);

   localparam int AW = $clog2(REGION_BYTES);
   localparam int CW = $clog2(REGION_BYTES + HDR_BYTES + (1 << LEN_W));
   localparam int WW = 2 + LEN_W;

   // header store: {status, length} per header byte offset
   logic [WW-1:0] mem [REGION_BYTES];

   logic             op_ff;
   logic [LEN_W-1:0] req_ff;
   logic [OFF_W-1:0] rel_ff;
   logic [CW-1:0]    cur_ff, cur_in;
   logic [LEN_W-1:0] used_ff, used_in;
   logic [LEN_W-1:0] region_ff;
   logic [AW-1:0]    clr_ff;
   logic [WW-1:0]    rd_ff;
   logic             rsp_valid_ff;
   logic [OFF_W-1:0] rsp_off_ff, rsp_off_in;
   code_type         rsp_code_ff;
   logic [LEN_W-1:0] rsp_used_ff;

   logic [1:0]       rd_status;
   logic [LEN_W-1:0] rd_len;
   logic [CW-1:0]    cap;
   logic [LEN_W:0]   total_new, total_old, addend;
   logic [LEN_W+1:0] used_sum;
   logic [OFF_W-1:0] rel_hdr;
   logic [AW-1:0]    rel_idx, cur_idx, rd_addr, wr_addr;
   logic             wr_en;
   logic [WW-1:0]    wr_data;

   assign rd_status = rd_ff[WW-1 -: 2];
   assign rd_len    = rd_ff[LEN_W-1:0];

   assign cap = (CW'(region_ff) < CW'(REGION_BYTES)) ? CW'(region_ff) : CW'(REGION_BYTES);

   assign total_new = (LEN_W+1)'(req_ff) + (LEN_W+1)'(HDR_BYTES);
   assign total_old = (LEN_W+1)'(rd_len) + (LEN_W+1)'(HDR_BYTES);

   assign rel_hdr = rel_ff - OFF_W'(HDR_BYTES);
   assign rel_idx = AW'(rel_hdr);
   assign cur_idx = cur_ff[AW-1:0];
   assign rd_addr = (op_ff == OP_RELEASE) ? rel_idx : cur_idx;

   // store write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_idx;
      wr_data = '0;
      if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (cmd.new_wr) begin
         wr_en   = 1'b1;
         wr_data = {ST_INUSE, req_ff};
      end else if (cmd.reuse_wr) begin
         wr_en   = 1'b1;
         wr_data = {ST_INUSE, rd_len};
      end else if (cmd.rel_wr) begin
         wr_en   = 1'b1;
         wr_addr = rel_idx;
         wr_data = {ST_FREED, rd_len};
      end
   end

   // usage counter, saturating both ways
   assign addend   = cmd.new_wr ? total_new : total_old;
   assign used_sum = (LEN_W+2)'(used_ff) + (LEN_W+2)'(addend);

   always_comb begin
      used_in = used_ff;
      if (cmd.new_wr || cmd.reuse_wr) begin
         used_in = (used_sum > (LEN_W+2)'({LEN_W{1'b1}})) ? {LEN_W{1'b1}}
                                                          : used_sum[LEN_W-1:0];
      end else if (cmd.rel_wr) begin
         used_in = ((LEN_W+1)'(used_ff) > total_old)
                   ? LEN_W'((LEN_W+1)'(used_ff) - total_old) : '0;
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.load) begin
         cur_in = CW'(USAGE_WORD);
      end else if (cmd.advance) begin
         cur_in = cur_ff + CW'(HDR_BYTES) + CW'(rd_len);
      end
   end

   assign rsp_off_in = cmd.grant ? (cur_ff[OFF_W-1:0] + OFF_W'(HDR_BYTES)) : '0;

   assign sts.clear_done = (clr_ff == AW'(REGION_BYTES - 1));
   assign sts.is_release = (op_ff == OP_RELEASE);
   assign sts.rel_bad    = (rel_ff < OFF_W'(HDR_BYTES))
                        || (32'(rel_hdr) >= 32'(REGION_BYTES));
   assign sts.zero_req   = (req_ff == '0);
   assign sts.cur_lt_cap = (cur_ff < cap);
   assign sts.fits       = ((cur_ff + CW'(total_new)) <= cap);
   assign sts.len_ge_n   = (rd_len >= req_ff);
   assign sts.status     = rd_status;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         region_ff    <= LEN_W'(CSR_RESET);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= cmd.respond;
         if (csr_we) begin
            region_ff <= csr_region_bytes;
         end
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.load) begin
         op_ff  <= req_opcode;
         req_ff <= req_request_bytes;
         rel_ff <= req_release_offset;
      end
      if (cmd.respond) begin
         rsp_off_ff  <= rsp_off_in;
         rsp_code_ff <= cmd.code;
         rsp_used_ff <= used_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_off_ff;
   assign rsp_result_code    = rsp_code_ff;
   assign rsp_bytes_in_use   = rsp_used_ff;

   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_wr, cmd.advance, cmd.new_wr, cmd.reuse_wr, cmd.rel_wr}))
      else $error("more than one store/pointer update in a cycle");

   a_write_with_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.new_wr || cmd.reuse_wr || cmd.rel_wr) |-> (cmd.respond && cmd.code == RC_OK))
      else $error("block state changed without an ok result");

   a_no_offset_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff != RC_OK) |-> (rsp_off_ff == '0))
      else $error("failed item carries a payload offset");

   a_release_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.rel_wr |=> (used_ff <= $past(used_ff)))
      else $error("release grew the usage count");

endmodule

// File: src/ffha_ctrl.sv
`timescale 1ns / 1ps
// Controller: state machine sequencing the clear pass, header walk and release.
module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_CHECK = 5'b00100,
      S_EVAL  = 5'b01000,
      S_REL   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_release) begin
               if (sts.rel_bad) begin
                  cmd.respond = 1'b1;
                  cmd.code    = RC_NOTUSED;
                  state_in    = S_IDLE;
               end else begin
                  state_in = S_REL;
               end
            end else if (sts.zero_req) begin
               cmd.respond = 1'b1;
               cmd.code    = RC_ZERO;
               state_in    = S_IDLE;
            end else if (!sts.cur_lt_cap) begin
               cmd.respond = 1'b1;
               cmd.code    = RC_NOSPACE;
               state_in    = S_IDLE;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (sts.status == ST_NEVER) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
               if (sts.fits) begin
                  cmd.new_wr = 1'b1;
                  cmd.grant  = 1'b1;
                  cmd.code   = RC_OK;
               end else begin
                  cmd.code = RC_NOSPACE;
               end
            end else if (sts.status == ST_FREED && sts.len_ge_n) begin
               cmd.reuse_wr = 1'b1;
               cmd.grant    = 1'b1;
               cmd.respond  = 1'b1;
               cmd.code     = RC_OK;
               state_in     = S_IDLE;
            end else begin
               // in use, freed but too short (or unknown status): skip over it
               cmd.advance = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_REL: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
            if (sts.status == ST_INUSE) begin
               cmd.rel_wr = 1'b1;
               cmd.code   = RC_OK;
            end else begin
               cmd.code = RC_NOTUSED;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_resp_ends_item: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == S_IDLE))
      else $error("controller did not return to idle after a result");

   a_load_sets_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy)
      else $error("busy low right after an item was taken");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule
